// ===== rtl/tss_pkg.sv =====
// Package with the shared types and constants of the thread-state scheduler.
package tss_pkg;

    localparam int MaxThreads = 16;
    localparam int NumSems    = 8;
    localparam int TidW       = 4;
    localparam int SemW       = 3;
    localparam int LenW       = 5;
    localparam int QDepth     = 2;

    typedef enum logic [3:0] {
        ACT_CREATE   = 4'd0,
        ACT_YIELD    = 4'd1,
        ACT_JOIN     = 4'd2,
        ACT_SUSPEND  = 4'd3,
        ACT_RESUME   = 4'd4,
        ACT_SEM_INIT = 4'd5,
        ACT_WAIT     = 4'd6,
        ACT_SIGNAL   = 4'd7,
        ACT_FINISH   = 4'd8
    } action_t;

    localparam logic [2:0] ST_FREE      = 3'd0;
    localparam logic [2:0] ST_READY     = 3'd1;
    localparam logic [2:0] ST_RUN       = 3'd2;
    localparam logic [2:0] ST_BLOCK     = 3'd3;
    localparam logic [2:0] ST_READY_SUS = 3'd4;
    localparam logic [2:0] ST_BLOCK_SUS = 3'd5;

    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_NOT_FOUND = 3'd1;
    localparam logic [2:0] STS_JOINED    = 3'd2;
    localparam logic [2:0] STS_NO_READY  = 3'd3;
    localparam logic [2:0] STS_EXHAUSTED = 3'd4;
    localparam logic [2:0] STS_BAD_QUEUE = 3'd5;

    typedef struct packed {
        logic [3:0]      action;
        logic [TidW-1:0] target_tid;
        logic [SemW-1:0] sem_index;
        logic [14:0]     init_count;
        logic            known;
        logic            needs_run;
    } cmd_t;

endpackage

// ===== rtl/tss_front.sv =====
// Front end: accepts commands, decodes them and holds them in a short queue.
module tss_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [3:0]         action,
    input  logic [3:0]         target_tid,
    input  logic [2:0]         sem_index,
    input  logic [14:0]        init_count,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output tss_pkg::cmd_t      cmd
);
    import tss_pkg::*;

    cmd_t        q_mem [QDepth];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  cnt_reg;
    logic        push, pop;
    cmd_t        dec;

    always_comb
    begin
        dec.action     = action;
        dec.target_tid = target_tid;
        dec.sem_index  = sem_index;
        dec.init_count = init_count;
        dec.known      = (action <= ACT_FINISH);
        dec.needs_run  = (action == ACT_YIELD) || (action == ACT_JOIN) ||
                         (action == ACT_WAIT) || (action == ACT_FINISH);
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2)
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 && !pop) |=> (cnt_reg == 2'd2))
        else $error("full queue lost an entry");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> !cmd_valid)
        else $error("empty queue presents a command");

endmodule

// ===== rtl/tss_back.sv =====
// Back end: executes one command at a time as a sequence of states and registers the result.
module tss_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  tss_pkg::cmd_t cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [2:0]    status,
    output logic [3:0]    running_tid,
    output logic          running_valid,
    output logic [3:0]    new_tid
);
    import tss_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_RM_SCAN, S_WAKE, S_DISPATCH, S_SHIFT, S_DONE
    } state_t;

    state_t          state_reg;
    cmd_t            cmd_reg;
    logic [2:0]      tstat_reg [MaxThreads];
    logic [TidW-1:0] rlist_reg [MaxThreads];
    logic [LenW-1:0] rlen_reg;
    logic [TidW-1:0] cur_reg;
    logic            cur_v_reg;
    logic [LenW-1:0] next_id_reg;
    logic            jw_v_reg [MaxThreads];
    logic [TidW-1:0] jw_t_reg [MaxThreads];
    logic [15:0]     sval_reg [NumSems];
    logic [TidW-1:0] swq_mem [NumSems*MaxThreads];
    logic [TidW-1:0] shead_reg [NumSems];
    logic [LenW-1:0] slen_reg [NumSems];
    logic [2:0]      err_reg;
    logic [TidW-1:0] ntid_reg;
    logic [LenW-1:0] i_reg, j_reg;
    logic [TidW-1:0] rm_t_reg, wake_t_reg;
    logic [TidW-1:0] head_rd_reg;
    logic            head_rd_ok_reg;
    logic            sig_pending_reg;
    logic            out_v_reg;
    logic [2:0]      o_status_reg;
    logic [3:0]      o_rtid_reg;
    logic            o_rv_reg;
    logic [3:0]      o_ntid_reg;

    logic [TidW-1:0] tgt;
    logic [2:0]      tst;
    logic [SemW-1:0] sx;
    logic [15:0]     sv;
    logic [TidW-1:0] slot;
    logic [2:0]      fin_err;
    state_t          exec_next;

    assign cmd_ready     = (state_reg == S_IDLE);
    assign out_valid     = out_v_reg;
    assign status        = o_status_reg;
    assign running_tid   = o_rtid_reg;
    assign running_valid = o_rv_reg;
    assign new_tid       = o_ntid_reg;

    assign tgt     = cmd_reg.target_tid;
    assign tst     = tstat_reg[tgt];
    assign sx      = cmd_reg.sem_index;
    assign sv      = sval_reg[sx];
    assign slot    = shead_reg[sx] + slen_reg[sx][TidW-1:0];
    assign fin_err = (err_reg == STS_OK && !cur_v_reg) ? STS_NO_READY : err_reg;

    always_comb
    begin
        exec_next = S_DISPATCH;
        if (!(cmd_reg.needs_run && !cur_v_reg))
        begin
            case (cmd_reg.action)
                ACT_SUSPEND:
                begin
                    if (tst == ST_READY)
                    begin
                        exec_next = S_RM_SCAN;
                    end
                end
                ACT_SIGNAL:
                begin
                    if (slen_reg[sx] != '0)
                    begin
                        exec_next = S_WAKE;
                    end
                end
                ACT_FINISH:
                begin
                    if (jw_v_reg[cur_reg])
                    begin
                        exec_next = S_WAKE;
                    end
                end
                default:
                begin
                    exec_next = S_DISPATCH;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EXEC && cmd_reg.action == ACT_WAIT && cur_v_reg
            && !($signed(sv) > 0) && !slen_reg[sx][LenW-1])
        begin
            swq_mem[{sx, slot}] <= cur_reg;
        end
        head_rd_reg <= swq_mem[{sx, shead_reg[sx]}];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int k = 0; k < MaxThreads; k++)
            begin
                tstat_reg[k] <= (k == 0) ? ST_RUN : ST_FREE;
                jw_v_reg[k]  <= 1'b0;
            end
            for (int k = 0; k < NumSems; k++)
            begin
                sval_reg[k]  <= '0;
                shead_reg[k] <= '0;
                slen_reg[k]  <= '0;
            end
            rlen_reg        <= '0;
            cur_reg         <= '0;
            cur_v_reg       <= 1'b1;
            next_id_reg     <= LenW'(1);
            out_v_reg       <= 1'b0;
            err_reg         <= STS_OK;
            sig_pending_reg <= 1'b0;
            head_rd_ok_reg  <= 1'b0;
        end
        else
        begin
            if (out_v_reg && out_ready && state_reg != S_DONE)
            begin
                out_v_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_reg         <= cmd;
                        err_reg         <= STS_OK;
                        ntid_reg        <= '0;
                        sig_pending_reg <= 1'b0;
                        head_rd_ok_reg  <= 1'b0;
                        state_reg       <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= exec_next;
                    if (cmd_reg.needs_run && !cur_v_reg)
                    begin
                        err_reg <= STS_NO_READY;
                    end
                    else
                    begin
                        case (cmd_reg.action)
                            ACT_CREATE:
                            begin
                                if (next_id_reg >= LenW'(MaxThreads))
                                begin
                                    err_reg <= STS_EXHAUSTED;
                                end
                                else
                                begin
                                    ntid_reg    <= next_id_reg[TidW-1:0];
                                    next_id_reg <= next_id_reg + 1'b1;
                                    rlist_reg[rlen_reg[TidW-1:0]] <= next_id_reg[TidW-1:0];
                                    rlen_reg <= rlen_reg + 1'b1;
                                    tstat_reg[next_id_reg[TidW-1:0]] <= ST_READY;
                                end
                            end
                            ACT_YIELD:
                            begin
                                cur_v_reg <= 1'b0;
                                if (!rlen_reg[LenW-1])
                                begin
                                    rlist_reg[rlen_reg[TidW-1:0]] <= cur_reg;
                                    rlen_reg <= rlen_reg + 1'b1;
                                    tstat_reg[cur_reg] <= ST_READY;
                                end
                            end
                            ACT_JOIN:
                            begin
                                if (!(tst inside {ST_READY, ST_BLOCK, ST_READY_SUS,
                                                  ST_BLOCK_SUS}))
                                begin
                                    err_reg <= STS_NOT_FOUND;
                                end
                                else if (jw_v_reg[tgt])
                                begin
                                    err_reg <= STS_JOINED;
                                end
                                else
                                begin
                                    jw_v_reg[tgt]      <= 1'b1;
                                    jw_t_reg[tgt]      <= cur_reg;
                                    tstat_reg[cur_reg] <= ST_BLOCK;
                                    cur_v_reg          <= 1'b0;
                                end
                            end
                            ACT_SUSPEND:
                            begin
                                if (tst == ST_READY)
                                begin
                                    tstat_reg[tgt] <= ST_READY_SUS;
                                    rm_t_reg       <= tgt;
                                    i_reg          <= '0;
                                    j_reg          <= '0;
                                end
                                else if (tst == ST_BLOCK)
                                begin
                                    tstat_reg[tgt] <= ST_BLOCK_SUS;
                                end
                                else
                                begin
                                    err_reg <= STS_NOT_FOUND;
                                end
                            end
                            ACT_RESUME:
                            begin
                                if (tst == ST_READY_SUS)
                                begin
                                    if (!rlen_reg[LenW-1])
                                    begin
                                        rlist_reg[rlen_reg[TidW-1:0]] <= tgt;
                                        rlen_reg <= rlen_reg + 1'b1;
                                        tstat_reg[tgt] <= ST_READY;
                                    end
                                end
                                else if (tst == ST_BLOCK_SUS)
                                begin
                                    tstat_reg[tgt] <= ST_BLOCK;
                                end
                                else
                                begin
                                    err_reg <= STS_NOT_FOUND;
                                end
                            end
                            ACT_SEM_INIT:
                            begin
                                sval_reg[sx]  <= {1'b0, cmd_reg.init_count};
                                shead_reg[sx] <= '0;
                                slen_reg[sx]  <= '0;
                            end
                            ACT_WAIT:
                            begin
                                if ($signed(sv) > 0)
                                begin
                                    sval_reg[sx] <= sv - 1'b1;
                                end
                                else if (slen_reg[sx][LenW-1])
                                begin
                                    err_reg <= STS_BAD_QUEUE;
                                end
                                else
                                begin
                                    if (sv != 16'h8000)
                                    begin
                                        sval_reg[sx] <= sv - 1'b1;
                                    end
                                    slen_reg[sx]       <= slen_reg[sx] + 1'b1;
                                    tstat_reg[cur_reg] <= ST_BLOCK;
                                    cur_v_reg          <= 1'b0;
                                end
                            end
                            ACT_SIGNAL:
                            begin
                                if (sv != 16'h7FFF)
                                begin
                                    sval_reg[sx] <= sv + 1'b1;
                                end
                                if (slen_reg[sx] != '0)
                                begin
                                    sig_pending_reg <= 1'b1;
                                end
                            end
                            ACT_FINISH:
                            begin
                                tstat_reg[cur_reg] <= ST_FREE;
                                cur_v_reg          <= 1'b0;
                                if (jw_v_reg[cur_reg])
                                begin
                                    jw_v_reg[cur_reg] <= 1'b0;
                                    wake_t_reg        <= jw_t_reg[cur_reg];
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_RM_SCAN:
                begin
                    if (i_reg < rlen_reg && !i_reg[LenW-1])
                    begin
                        if (rlist_reg[i_reg[TidW-1:0]] != rm_t_reg)
                        begin
                            rlist_reg[j_reg[TidW-1:0]] <= rlist_reg[i_reg[TidW-1:0]];
                            j_reg <= j_reg + 1'b1;
                        end
                        i_reg <= i_reg + 1'b1;
                    end
                    else
                    begin
                        rlen_reg  <= j_reg;
                        state_reg <= S_DISPATCH;
                    end
                end
                S_WAKE:
                begin
                    // A signal first waits for the registered queue head read.
                    if (sig_pending_reg && !head_rd_ok_reg)
                    begin
                        head_rd_ok_reg <= 1'b1;
                    end
                    else
                    begin
                        logic [TidW-1:0] w;
                        w = sig_pending_reg ? head_rd_reg : wake_t_reg;
                        state_reg <= S_DISPATCH;
                        if (tstat_reg[w] == ST_BLOCK || tstat_reg[w] == ST_BLOCK_SUS)
                        begin
                            if (tstat_reg[w] == ST_BLOCK_SUS)
                            begin
                                tstat_reg[w] <= ST_READY_SUS;
                            end
                            else if (!rlen_reg[LenW-1])
                            begin
                                rlist_reg[rlen_reg[TidW-1:0]] <= w;
                                rlen_reg     <= rlen_reg + 1'b1;
                                tstat_reg[w] <= ST_READY;
                            end
                            if (sig_pending_reg)
                            begin
                                shead_reg[sx] <= shead_reg[sx] + 1'b1;
                                slen_reg[sx]  <= slen_reg[sx] - 1'b1;
                            end
                        end
                        else if (sig_pending_reg)
                        begin
                            err_reg <= STS_BAD_QUEUE;
                        end
                    end
                end
                S_DISPATCH:
                begin
                    if (!cur_v_reg && rlen_reg != '0)
                    begin
                        cur_reg   <= rlist_reg[0];
                        cur_v_reg <= 1'b1;
                        tstat_reg[rlist_reg[0]] <= ST_RUN;
                        i_reg     <= LenW'(1);
                        state_reg <= S_SHIFT;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_SHIFT:
                begin
                    if (i_reg < rlen_reg && !i_reg[LenW-1])
                    begin
                        rlist_reg[i_reg[TidW-1:0] - 1'b1] <= rlist_reg[i_reg[TidW-1:0]];
                        i_reg <= i_reg + 1'b1;
                    end
                    else
                    begin
                        rlen_reg  <= rlen_reg - 1'b1;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_v_reg || out_ready)
                    begin
                        out_v_reg    <= 1'b1;
                        o_status_reg <= fin_err;
                        o_rtid_reg   <= cur_v_reg ? cur_reg : '0;
                        o_rv_reg     <= cur_v_reg;
                        o_ntid_reg   <= ntid_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        rlen_reg <= LenW'(MaxThreads))
        else $error("ready list overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        cur_v_reg |-> (state_reg != S_IDLE || tstat_reg[cur_reg] == ST_RUN))
        else $error("running thread not in run state");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && (!out_v_reg || out_ready)) |=> out_v_reg)
        else $error("result not presented");
    assert property (@(posedge clk) disable iff (!rst_n)
        next_id_reg <= LenW'(MaxThreads))
        else $error("thread id counter overflow");

endmodule

// ===== rtl/thread_state_scheduler_top.sv =====
// Top level of the thread-state scheduler: decode front end, queue and executor.
// Each command passes decode, the queue and the executor; a dispatch then shifts the ready list,
// suspend of a ready thread first scans the ready list, a signal with waiters reads the queue head
// and wakes it, and a finish with a join waiter wakes that waiter. The executor takes one
// command at a time; output stalls hold it in its result state.
// Reset: thread 0 running, all other threads free, semaphores zero, queues empty.
module thread_state_scheduler_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  action,
    input  logic [3:0]  target_tid,
    input  logic [2:0]  sem_index,
    input  logic [14:0] init_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [3:0]  running_tid,
    output logic        running_valid,
    output logic [3:0]  new_tid
);
    import tss_pkg::*;

    cmd_t cmd;
    logic cmd_valid, cmd_ready;

    tss_front u_front (
        .clk, .rst_n, .in_valid, .in_ready, .action, .target_tid, .sem_index,
        .init_count, .cmd_valid, .cmd_ready, .cmd
    );

    tss_back u_back (
        .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd, .out_valid, .out_ready,
        .status, .running_tid, .running_valid, .new_tid
    );

endmodule

// ===== tb/sv/tss_checker.sv =====
// Checker that predicts every scheduler result and compares it with the block's output.
`timescale 1ns / 100ps
module tss_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [3:0]  action,
    input  logic [3:0]  target_tid,
    input  logic [2:0]  sem_index,
    input  logic [14:0] init_count,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  status,
    input  logic [3:0]  running_tid,
    input  logic        running_valid,
    input  logic [3:0]  new_tid,
    output int          errors,
    output int          outstanding
);
    import tss_pkg::*;

    typedef struct {
        logic [2:0] sts;
        logic [3:0] run_tid;
        logic       run_ok;
        logic [3:0] made_tid;
    } sched_result_t;

    sched_result_t awaited_results[$];

    logic [2:0]        thr_st [MaxThreads];
    logic [3:0]        rdy_list [MaxThreads];
    int                rdy_len;
    logic [3:0]        cur_tid;
    logic              cur_ok;
    int                next_tid;
    logic [4:0]        joiner [MaxThreads];
    int                sem_cnt [NumSems];
    logic [3:0]        sem_q [NumSems][MaxThreads];
    int                sq_head [NumSems];
    int                sq_len [NumSems];

    initial
    begin
        errors = 0;
        outstanding = 0;
        for (int i = 0; i < MaxThreads; i++)
        begin
            thr_st[i] = ST_FREE;
            joiner[i] = '0;
            rdy_list[i] = '0;
        end
        thr_st[0] = ST_RUN;
        rdy_len = 0;
        cur_tid = '0;
        cur_ok = 1'b1;
        next_tid = 1;
        for (int s = 0; s < NumSems; s++)
        begin
            sem_cnt[s] = 0;
            sq_head[s] = 0;
            sq_len[s] = 0;
        end
    end

    function automatic int clamp16(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic void ready_append(logic [3:0] t);
        if (rdy_len < MaxThreads)
        begin
            rdy_list[rdy_len] = t;
            rdy_len++;
            thr_st[t] = ST_READY;
        end
    endfunction

    function automatic void ready_drop(logic [3:0] t);
        int j;
        j = 0;
        for (int i = 0; i < rdy_len; i++)
        begin
            if (rdy_list[i] != t)
            begin
                rdy_list[j] = rdy_list[i];
                j++;
            end
        end
        rdy_len = j;
    endfunction

    function automatic bit wake_thread(logic [3:0] t);
        if (thr_st[t] == ST_BLOCK)
        begin
            ready_append(t);
            return 1'b1;
        end
        if (thr_st[t] == ST_BLOCK_SUS)
        begin
            thr_st[t] = ST_READY_SUS;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic sched_result_t schedule_cmd(logic [3:0] act, logic [3:0] tid,
                                                   logic [2:0] s, logic [14:0] cnt);
        sched_result_t r;
        logic [2:0] err;
        logic [3:0] made;
        logic [2:0] st;
        logic [3:0] cur;
        logic [3:0] w;
        int v;
        int slot;
        bit needs_run;
        err = STS_OK;
        made = '0;
        cur = cur_tid;
        needs_run = (act == ACT_YIELD || act == ACT_JOIN || act == ACT_WAIT
                     || act == ACT_FINISH);
        if (needs_run && !cur_ok)
        begin
            err = STS_NO_READY;
        end
        else if (act == ACT_CREATE)
        begin
            if (next_tid >= MaxThreads)
            begin
                err = STS_EXHAUSTED;
            end
            else
            begin
                made = next_tid[3:0];
                next_tid++;
                ready_append(made);
            end
        end
        else if (act == ACT_YIELD)
        begin
            cur_ok = 1'b0;
            ready_append(cur);
        end
        else if (act == ACT_JOIN)
        begin
            st = thr_st[tid];
            if (st != ST_READY && st != ST_BLOCK && st != ST_READY_SUS && st != ST_BLOCK_SUS)
            begin
                err = STS_NOT_FOUND;
            end
            else if (joiner[tid][4])
            begin
                err = STS_JOINED;
            end
            else
            begin
                joiner[tid] = {1'b1, cur};
                thr_st[cur] = ST_BLOCK;
                cur_ok = 1'b0;
            end
        end
        else if (act == ACT_SUSPEND || act == ACT_RESUME)
        begin
            st = thr_st[tid];
            if (act == ACT_SUSPEND && st == ST_READY)
            begin
                ready_drop(tid);
                thr_st[tid] = ST_READY_SUS;
            end
            else if (act == ACT_SUSPEND && st == ST_BLOCK)
            begin
                thr_st[tid] = ST_BLOCK_SUS;
            end
            else if (act == ACT_RESUME && st == ST_READY_SUS)
            begin
                ready_append(tid);
            end
            else if (act == ACT_RESUME && st == ST_BLOCK_SUS)
            begin
                thr_st[tid] = ST_BLOCK;
            end
            else
            begin
                err = STS_NOT_FOUND;
            end
        end
        else if (act == ACT_SEM_INIT)
        begin
            sem_cnt[s] = int'(cnt);
            sq_head[s] = 0;
            sq_len[s] = 0;
        end
        else if (act == ACT_WAIT)
        begin
            v = sem_cnt[s];
            if (v > 0)
            begin
                sem_cnt[s] = v - 1;
            end
            else if (sq_len[s] >= MaxThreads)
            begin
                err = STS_BAD_QUEUE;
            end
            else
            begin
                slot = (sq_head[s] + sq_len[s]) % MaxThreads;
                sem_cnt[s] = clamp16(v - 1);
                sem_q[s][slot] = cur;
                sq_len[s]++;
                thr_st[cur] = ST_BLOCK;
                cur_ok = 1'b0;
            end
        end
        else if (act == ACT_SIGNAL)
        begin
            sem_cnt[s] = clamp16(sem_cnt[s] + 1);
            if (sq_len[s] > 0)
            begin
                if (wake_thread(sem_q[s][sq_head[s]]))
                begin
                    sq_head[s] = (sq_head[s] + 1) % MaxThreads;
                    sq_len[s]--;
                end
                else
                begin
                    err = STS_BAD_QUEUE;
                end
            end
        end
        else if (act == ACT_FINISH)
        begin
            if (joiner[cur][4])
            begin
                w = joiner[cur][3:0];
                joiner[cur] = '0;
                void'(wake_thread(w));
            end
            thr_st[cur] = ST_FREE;
            cur_ok = 1'b0;
        end
        if (!cur_ok && rdy_len > 0)
        begin
            cur_tid = rdy_list[0];
            for (int i = 1; i < rdy_len; i++) rdy_list[i-1] = rdy_list[i];
            rdy_len--;
            thr_st[cur_tid] = ST_RUN;
            cur_ok = 1'b1;
        end
        if (err == STS_OK && !cur_ok) err = STS_NO_READY;
        r.sts = err;
        r.run_tid = cur_ok ? cur_tid : 4'd0;
        r.run_ok = cur_ok;
        r.made_tid = made;
        return r;
    endfunction

    task automatic report_mismatch(string what, int want, int got);
        $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
        errors++;
    endtask

    always @(posedge clk)
    begin
        sched_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    report_mismatch("unexpected transfer, queued results", 0, 1);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (status !== want.sts) report_mismatch("status", want.sts, status);
                    if (running_tid !== want.run_tid)
                        report_mismatch("running_tid", want.run_tid, running_tid);
                    if (running_valid !== want.run_ok)
                        report_mismatch("running_valid", want.run_ok, running_valid);
                    if (new_tid !== want.made_tid)
                        report_mismatch("new_tid", want.made_tid, new_tid);
                end
            end
            if (in_valid && in_ready)
                awaited_results.push_back(schedule_cmd(action, target_tid, sem_index,
                                                       init_count));
            outstanding = awaited_results.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top: stimulus, flow control and verdict for the thread-state scheduler.
`timescale 1ns / 100ps
module tb;
    import tss_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [3:0]  action;
    logic [3:0]  target_tid;
    logic [2:0]  sem_index;
    logic [14:0] init_count;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [3:0]  running_tid;
    logic        running_valid;
    logic [3:0]  new_tid;
    int          errors;
    int          outstanding;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          recv_hold;
    int          cycle_count;

    thread_state_scheduler_top dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .target_tid(target_tid), .sem_index(sem_index),
        .init_count(init_count), .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .running_tid(running_tid), .running_valid(running_valid),
        .new_tid(new_tid)
    );

    tss_checker u_checker (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .target_tid(target_tid), .sem_index(sem_index),
        .init_count(init_count), .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .running_tid(running_tid), .running_valid(running_valid),
        .new_tid(new_tid), .errors(errors), .outstanding(outstanding)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 600000)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        if (recv_hold) out_ready <= 1'b0;
        else out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic send_cmd(logic [3:0] a, logic [3:0] t, logic [2:0] s, logic [14:0] c);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid <= 1'b1;
        action <= a;
        target_tid <= t;
        sem_index <= s;
        init_count <= c;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic send_random;
        int pick;
        logic [3:0] a;
        pick = $urandom_range(0, 99);
        if (pick < 12) a = ACT_CREATE;
        else if (pick < 24) a = ACT_YIELD;
        else if (pick < 32) a = ACT_JOIN;
        else if (pick < 42) a = ACT_SUSPEND;
        else if (pick < 54) a = ACT_RESUME;
        else if (pick < 60) a = ACT_SEM_INIT;
        else if (pick < 74) a = ACT_WAIT;
        else if (pick < 88) a = ACT_SIGNAL;
        else if (pick < 96) a = ACT_FINISH;
        else a = 4'($urandom_range(9, 15));
        send_cmd(a, 4'($urandom), 3'($urandom),
                 ($urandom_range(0, 1) == 1) ? 15'($urandom) : 15'($urandom_range(0, 3)));
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = '0;
        target_tid = '0;
        sem_index = '0;
        init_count = '0;
        out_ready = 1'b0;
        recv_hold = 1'b0;
        send_idle_pct = 33;
        recv_idle_pct = 71;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        send_cmd(ACT_JOIN, 4'd0, 3'd0, 15'd0);
        send_cmd(ACT_JOIN, 4'd15, 3'd0, 15'd0);
        send_cmd(ACT_YIELD, 4'd0, 3'd0, 15'd0);
        send_cmd(ACT_CREATE, 4'd0, 3'd0, 15'd0);
        send_cmd(ACT_CREATE, 4'd0, 3'd0, 15'd0);
        send_cmd(ACT_CREATE, 4'd0, 3'd0, 15'd0);
        send_cmd(ACT_SUSPEND, 4'd2, 3'd0, 15'd0);
        send_cmd(ACT_RESUME, 4'd2, 3'd0, 15'd0);
        send_cmd(ACT_RESUME, 4'd15, 3'd0, 15'd0);
        send_cmd(ACT_JOIN, 4'd1, 3'd0, 15'd0);
        send_cmd(ACT_JOIN, 4'd1, 3'd0, 15'd0);
        send_cmd(ACT_SEM_INIT, 4'd0, 3'd7, 15'h7fff);
        send_cmd(ACT_SIGNAL, 4'd0, 3'd7, 15'd0);
        send_cmd(ACT_SEM_INIT, 4'd0, 3'd0, 15'd0);
        send_cmd(ACT_WAIT, 4'd0, 3'd0, 15'd0);
        send_cmd(ACT_SUSPEND, 4'd3, 3'd0, 15'd0);
        send_cmd(ACT_SIGNAL, 4'd0, 3'd0, 15'd0);
        send_cmd(ACT_FINISH, 4'd0, 3'd0, 15'd0);
        send_cmd(ACT_FINISH, 4'd0, 3'd0, 15'd0);
        send_cmd(ACT_FINISH, 4'd0, 3'd0, 15'd0);
        send_cmd(ACT_YIELD, 4'd0, 3'd0, 15'd0);
        send_cmd(4'd15, 4'd0, 3'd0, 15'd0);
        send_cmd(ACT_RESUME, 4'd3, 3'd0, 15'd0);

        for (int i = 0; i < 500; i++)
        begin
            if (i == 170)
            begin
                send_idle_pct = 71;
                recv_idle_pct = 33;
            end
            if (i == 340)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (i == 100)
            begin
                fork
                    begin
                        recv_hold = 1'b1;
                        repeat (300) @(posedge clk);
                        recv_hold = 1'b0;
                    end
                join_none
            end
            if (i == 250)
            begin
                in_valid <= 1'b0;
                wait (outstanding == 0);
                repeat (40) @(negedge clk);
            end
            send_random();
        end
        in_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
